[rtl/cfp_pkg.sv]
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and codes for the character frequency percentage block.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam logic [1:0] FUNC_TEXT  = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [7:0]  TERM_RESET = 8'd35;
    localparam logic [6:0]  PCT_MUL    = 7'd100;
    localparam logic [14:0] PCT_MAX    = 15'd25600;
    localparam int          PCT_W      = 15;

    typedef enum logic [1:0] {
        ST_REPORTED,
        ST_DUPLICATE,
        ST_TERMINATOR,
        ST_SET_FULL
    } status_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_value;
    } item_t;

    typedef struct packed {
        logic [6:0]  set_position;
        logic [7:0]  reported_char;
        logic [14:0] occurrences;
        logic [14:0] percent_q8;
        status_t     status;
    } result_t;

endpackage

[rtl/cfp_div.sv]
// ----------------------------------------------------------------------------
// cfp_div
// Restoring divider, one quotient bit per cycle, fifteen quotient bits.
// ----------------------------------------------------------------------------
module cfp_div #(
    parameter int CNT_W = 15
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [CNT_W+14:0]       num,
    input  logic [CNT_W-1:0]        den,
    output logic                    done,
    output logic [cfp_pkg::PCT_W-1:0] quot
);
    import cfp_pkg::*;

    // The caller guarantees num < den * 2**PCT_W, so the upper part of the
    // numerator already lies below the divisor.
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [PCT_W-1:0] num_lo_reg;
    logic [PCT_W-1:0] quot_reg;
    logic [CNT_W-1:0] den_reg;
    logic [3:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W:0]   trial;
    logic             qbit;

    always_comb
    begin
        trial = {rem_reg, num_lo_reg[PCT_W-1]};
        qbit  = (trial >= {1'b0, den_reg});
        if (qbit)
        begin
            rem_next = CNT_W'(trial - {1'b0, den_reg});
        end
        else
        begin
            rem_next = trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg    <= num[CNT_W+14:PCT_W];
                num_lo_reg <= num[PCT_W-1:0];
                den_reg    <= den;
                cnt_reg    <= '0;
                busy_reg   <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg    <= rem_next;
                num_lo_reg <= {num_lo_reg[PCT_W-2:0], 1'b0};
                quot_reg   <= {quot_reg[PCT_W-2:0], qbit};
                cnt_reg    <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(PCT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[rtl/char_frequency_percent.sv]
// ----------------------------------------------------------------------------
// char_frequency_percent
// Character histogram over a text with a percentage report per character.
// ----------------------------------------------------------------------------
// For a text byte, the single-port histogram memory is read in the cycle of
// acceptance and written back in the next. A clear transaction leaves the
// histogram memory, which also holds the reported flag of each character
// beside its count, untouched, since that memory is tracked by per-entry valid
// bits. A query that yields only a status skips the divider; a new character
// with a nonzero text length waits for the fifteen steps of the bit-serial
// divider. A result then waits in the output register while the next
// transaction is accepted; a query finishing while the previous result is
// still stalled waits for it to drain.
module char_frequency_percent #(
    parameter int MAX_TEXT = 16384,
    parameter int MAX_SET  = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  cfp_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output cfp_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);
    import cfp_pkg::*;

    localparam int CNT_W = $clog2(MAX_TEXT + 1);
    localparam int SET_W = $clog2(MAX_SET + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_OUT
    } state_t;

    state_t            state_reg;
    item_t             item_reg;
    logic [7:0]        term_reg;
    logic [CNT_W-1:0]  length_reg;
    logic [SET_W-1:0]  set_count_reg;
    logic [255:0]      hist_vld_reg;
    logic              vld_q_reg;
    logic [CNT_W:0]    mem_q_reg;
    logic [CNT_W-1:0]  occ_reg;
    logic [PCT_W-1:0]  pct_reg;
    status_t           status_reg;
    logic              result_valid_reg;
    result_t           result_reg;

    // Each entry holds the reported flag above the occurrence count.
    logic [CNT_W:0]    hist_mem [256];

    logic              accept;
    logic              mem_we;
    logic [CNT_W:0]    mem_wdata;
    logic              seen_cur;
    logic [CNT_W-1:0]  occ_cur;
    logic [CNT_W-1:0]  occ_inc;
    logic              div_start;
    logic              div_done;
    logic [PCT_W-1:0]  div_quot;
    logic [CNT_W+6:0]  product;
    logic [CNT_W+14:0] div_num;
    logic [CNT_W+14:0] occ_wide;
    logic [SET_W+6:0]  pos_wide;
    logic              out_free;

    assign accept    = item_valid && (state_reg == S_IDLE);
    assign item_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !result_valid_reg || !result_stall;

    assign seen_cur = vld_q_reg && mem_q_reg[CNT_W];
    assign occ_cur = vld_q_reg ? mem_q_reg[CNT_W-1:0] : '0;
    assign occ_inc = (occ_cur < CNT_W'(MAX_TEXT)) ? occ_cur + CNT_W'(1) : occ_cur;
    assign mem_we  = ((state_reg == S_READ) && (item_reg.func == FUNC_TEXT)) ||
                     ((state_reg == S_OUT) && out_free && (status_reg == ST_REPORTED));
    assign mem_wdata = (state_reg == S_READ) ? {seen_cur, occ_inc} : {1'b1, occ_reg};

    assign product   = (CNT_W+7)'(occ_reg) * (CNT_W+7)'(PCT_MUL);
    assign div_num   = {product, 8'b0};
    assign div_start = (state_reg == S_MUL);

    assign occ_wide = {15'b0, occ_reg};
    assign pos_wide = {7'b0, set_count_reg};

    cfp_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (length_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_q_reg <= hist_mem[item.char_value];
        end
        if (mem_we)
        begin
            hist_mem[item_reg.char_value] <= mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            term_reg         <= TERM_RESET;
            length_reg       <= '0;
            set_count_reg    <= '0;
            hist_vld_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                term_reg <= cfg_data;
            end
            if (result_valid_reg && !result_stall && !((state_reg == S_OUT) && out_free))
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg  <= item;
                        vld_q_reg <= hist_vld_reg[item.char_value];
                        if (item.func == FUNC_CLEAR)
                        begin
                            hist_vld_reg  <= '0;
                            length_reg    <= '0;
                            set_count_reg <= '0;
                        end
                        else if ((item.func == FUNC_QUERY) ||
                                 ((item.func == FUNC_TEXT) && (item.char_value != 8'd0)))
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    if (item_reg.func == FUNC_TEXT)
                    begin
                        hist_vld_reg[item_reg.char_value] <= 1'b1;
                        if (length_reg < CNT_W'(MAX_TEXT))
                        begin
                            length_reg <= length_reg + CNT_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        occ_reg <= occ_cur;
                        pct_reg <= '0;
                        if (item_reg.char_value == term_reg)
                        begin
                            status_reg <= ST_TERMINATOR;
                            state_reg  <= S_OUT;
                        end
                        else if (seen_cur)
                        begin
                            status_reg <= ST_DUPLICATE;
                            state_reg  <= S_OUT;
                        end
                        else if (set_count_reg == SET_W'(MAX_SET))
                        begin
                            status_reg <= ST_SET_FULL;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            status_reg <= ST_REPORTED;
                            state_reg  <= (length_reg == '0) ? S_OUT : S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        pct_reg   <= div_quot;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        result_valid_reg           <= 1'b1;
                        result_reg.reported_char   <= item_reg.char_value;
                        result_reg.status          <= status_reg;
                        if (status_reg == ST_REPORTED)
                        begin
                            result_reg.set_position <= pos_wide[6:0];
                            result_reg.occurrences  <= occ_wide[14:0];
                            result_reg.percent_q8   <= pct_reg;
                            hist_vld_reg[item_reg.char_value] <= 1'b1;
                            set_count_reg <= set_count_reg + SET_W'(1);
                        end
                        else
                        begin
                            result_reg.set_position <= '0;
                            result_reg.occurrences  <= '0;
                            result_reg.percent_q8   <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/cfp_checker.sv]
// ----------------------------------------------------------------------------
// cfp_checker
// Port-level assertions for the character frequency percentage block.
// ----------------------------------------------------------------------------
module cfp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input cfp_pkg::item_t    item,
    input logic              result_valid,
    input logic              result_stall,
    input cfp_pkg::result_t  result,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [7:0]        cfg_data
);
    import cfp_pkg::*;

    // A result that is held off keeps its contents.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

    // An accepted query raises the item stall, so the block goes busy.
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (item.func == FUNC_QUERY)) |=> item_stall)
        else $error("query accepted without going busy");

    // A share of the text never exceeds one hundred percent.
    a_pct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == ST_REPORTED)) |->
        (result.percent_q8 <= PCT_MAX))
        else $error("percentage out of range");

    // Status-only results carry no position, count or share.
    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != ST_REPORTED)) |->
        ((result.set_position == 7'd0) && (result.occurrences == 15'd0) &&
         (result.percent_q8 == 15'd0)))
        else $error("status-only result carries data");

endmodule

bind char_frequency_percent cfp_checker u_cfp_checker (.*);
